// ----- hw/rtl/rldm_pkg.sv -----
// Shared types, widths and constants of the radial lens distortion map.
package rldm_pkg;

  // Field and datapath widths.
  localparam int CW     = 40;   // coordinate, 28 fraction bits
  localparam int DW     = 41;   // offset from the centre
  localparam int KW     = 48;   // coefficient, 40 fraction bits
  localparam int AW     = 64;   // Horner accumulator and scaled products
  localparam int PW     = 128;  // full product of two 64 bit magnitudes
  localparam int SSW    = 82;   // sum of squared offsets
  localparam int RTW    = 41;   // radius
  localparam int TOLW   = 20;   // convergence limit
  localparam int CFG_IW = 3;    // register index
  localparam int CFG_DW = 48;   // widest register

  localparam int MAX_ROUNDS_DEF = 50;

  // Register indexes.
  localparam logic [CFG_IW-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COEFF_0  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COEFF_1  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COEFF_2  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_COEFF_3  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_COEFF_4  = 3'd6;
  localparam logic [CFG_IW-1:0] REG_TOL      = 3'd7;

  // Request kinds.
  localparam logic KIND_UNDISTORT = 1'b0;
  localparam logic KIND_DISTORT   = 1'b1;

  localparam logic [TOLW-1:0] TOL_RESET   = 20'd268;
  localparam logic [RTW-1:0]  NEAR_CENTRE = 41'd268;

  localparam logic signed [AW-1:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AW-1:0] INT64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [CW-1:0] C40_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic signed [CW-1:0] C40_MIN   = 40'sh80_0000_0000;

  typedef struct packed {
    logic                 kind;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 converged;
  } out_item_t;

endpackage

// ----- hw/rtl/rldm_mul.sv -----
// Multi-cycle signed 64 by 64 multiplier built on one 32 by 32 partial product.
module rldm_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic signed [rldm_pkg::AW-1:0] a,
  input  logic signed [rldm_pkg::AW-1:0] b,
  output logic                           done,
  output logic        [rldm_pkg::PW-1:0] prod,
  output logic                           neg
);
  import rldm_pkg::*;

  logic          busy_r;
  logic [2:0]    cnt_r;
  logic [AW-1:0] am_r, bm_r;
  logic [AW-1:0] pp_r;
  logic [1:0]    ppk_r;
  logic [PW-1:0] acc_r;
  logic          neg_r;
  logic          done_r;
  logic [31:0]   a_part, b_part;
  logic [PW-1:0] pp_shift;

  // Select the operand halves for the current partial product.
  assign a_part = cnt_r[1] ? am_r[63:32] : am_r[31:0];
  assign b_part = cnt_r[0] ? bm_r[63:32] : bm_r[31:0];

  // Align the registered partial product to its weight.
  always_comb begin
    unique case (ppk_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd1:    pp_shift = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shift = {32'd0, pp_r, 32'd0};
      default: pp_shift = {pp_r, 64'd0};
    endcase
  end

  // Sequencer: four partial products, each registered and accumulated in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        am_r   <= a[AW-1] ? AW'(0 - a) : AW'(a);
        bm_r   <= b[AW-1] ? AW'(0 - b) : AW'(b);
        neg_r  <= a[AW-1] ^ b[AW-1];
        acc_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd4) begin
          pp_r  <= {32'd0, a_part} * {32'd0, b_part};
          ppk_r <= cnt_r[1:0];
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_r + pp_shift;
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
  assign neg  = neg_r;

endmodule

// ----- hw/rtl/rldm_sqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
module rldm_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [rldm_pkg::SSW-1:0]       rad,
  output logic                           done,
  output logic [rldm_pkg::RTW-1:0]       root
);
  import rldm_pkg::*;

  logic           busy_r;
  logic           done_r;
  logic [5:0]     cnt_r;
  logic [SSW-1:0] rad_r;
  logic [45:0]    rem_r;
  logic [RTW-1:0] root_r;
  logic [45:0]    rem_sh;
  logic [45:0]    trial;
  logic           take;

  // One restoring step: bring down two bits and try the next root bit.
  assign rem_sh = {rem_r[43:0], rad_r[SSW-1:SSW-2]};
  assign trial  = {3'b000, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(RTW);
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[SSW-3:0], 2'b00};
        rem_r  <= take ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[RTW-2:0], take};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hw/rtl/radial_lens_distortion_map_core.sv -----
// Top level of the radial lens distortion map: sequencer, registers and datapath.
//
// Usage: a request (kind, in_x, in_y) is taken at a clock edge with start high and busy
// low. kind 1 distorts the point with the quartic radial factor about the centre; kind 0
// undistorts it by fixed-point iteration. One result (out_x, out_y, converged) appears on
// out_data for exactly one cycle with out_valid high; it must be taken then, since the
// receiver cannot stall the block. busy stays high from acceptance until the result cycle.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at the next edge; the user
// makes them only while busy is low, which the block itself does not enforce.
// Sequence: one round is an offset step, two squarings on the shared multiplier, the
// bit-serial square root, four Horner products and two displacement products. Distort
// takes one round (ending after the square root near the centre); undistort takes up
// to MAX_ROUNDS rounds. One request is in work at a time.
// Reset: synchronous, active low; returns to idle, centre and coefficients to zero and
// the convergence limit to 268.
module radial_lens_distortion_map_core #(
  parameter int MAX_ROUNDS = rldm_pkg::MAX_ROUNDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rldm_pkg::in_item_t           in_data,
  output logic                         out_valid,
  output rldm_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [rldm_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [rldm_pkg::CFG_DW-1:0]  cfg_data
);
  import rldm_pkg::*;

  localparam int RND_W = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_OFFS = 8'b0000_0010,
    S_SQX  = 8'b0000_0100,
    S_SQY  = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_HORN = 8'b0010_0000,
    S_DSPX = 8'b0100_0000,
    S_DSPY = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [KW-1:0] k_r [5];
  logic [TOLW-1:0]      tol_r;

  // Working registers.
  logic                 kind_r;
  logic signed [CW-1:0] x_r, y_r, tx_r, ty_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [SSW-1:0]       sumsq_r;
  logic [RTW-1:0]       r_r;
  logic signed [AW-1:0] acc_r, mx_r;
  logic [2:0]           hstep_r;
  logic [RND_W-1:0]     round_r;
  logic                 mul_go_r, sqrt_go_r;
  logic signed [AW-1:0] mul_a_r, mul_b_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  // Shared unit outputs.
  logic                 mul_done, mul_neg;
  logic [PW-1:0]        mul_prod;
  logic                 sqrt_done;
  logic [RTW-1:0]       sqrt_root;

  logic signed [DW-1:0] dxw, dyw;
  logic signed [AW-1:0] m28, m40, hsum;
  logic signed [CW-1:0] ox_n, oy_n;
  logic signed [DW-1:0] ddx, ddy;
  logic                 conv;

  // Scale a product magnitude down, round half away from zero, saturate to 64 bits.
  function automatic logic signed [AW-1:0] mulq_fin(input logic [PW-1:0] p, input logic neg,
                                                    input logic sh40);
    logic [PW-1:0] q;
    if (sh40) q = (p + (PW'(1) << 39)) >> 40;
    else      q = (p + (PW'(1) << 27)) >> 28;
    if (neg) begin
      if (q >= (PW'(1) << 63)) return INT64_MIN;
      return AW'(0 - q[AW-1:0]);
    end
    if (q > PW'(INT64_MAX)) return INT64_MAX;
    return AW'(q[AW-1:0]);
  endfunction

  // Saturating 64 bit addition.
  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                   input logic signed [AW-1:0] b);
    logic signed [AW:0] s;
    s = {a[AW-1], a} + {b[AW-1], b};
    if (s[AW] != s[AW-1]) return s[AW] ? INT64_MIN : INT64_MAX;
    return s[AW-1:0];
  endfunction

  // Coordinate plus displacement, clamped to the 40 bit range.
  function automatic logic signed [CW-1:0] coord_add(input logic signed [CW-1:0] p,
                                                     input logic signed [AW-1:0] d);
    logic signed [AW+1:0] s;
    s = {{(AW+2-CW){p[CW-1]}}, p} + {{2{d[AW-1]}}, d};
    if (s > (AW+2)'(C40_MAX)) return C40_MAX;
    if (s < (AW+2)'(C40_MIN)) return C40_MIN;
    return s[CW-1:0];
  endfunction

  // Offsets of the current iterate from the centre.
  assign dxw = {tx_r[CW-1], tx_r} - {cx_r[CW-1], cx_r};
  assign dyw = {ty_r[CW-1], ty_r} - {cy_r[CW-1], cy_r};

  // Scaled products and the Horner step.
  assign m28  = mulq_fin(mul_prod, mul_neg, 1'b0);
  assign m40  = mulq_fin(mul_prod, mul_neg, 1'b1);
  assign hsum = sat_add(AW'(k_r[hstep_r]), m28);

  // New point: distort adds the displacement, undistort subtracts it (clamped to 40 bits).
  assign ox_n = coord_add(x_r, (kind_r == KIND_DISTORT) ? mx_r : AW'(0 - mx_r));
  assign oy_n = coord_add(y_r, (kind_r == KIND_DISTORT) ? m40 : AW'(0 - m40));

  // Convergence test against the previous iterate.
  assign ddx  = {ox_n[CW-1], ox_n} - {tx_r[CW-1], tx_r};
  assign ddy  = {oy_n[CW-1], oy_n} - {ty_r[CW-1], ty_r};
  assign conv = (round_r != '0)
             && ((ddx[DW-1] ? DW'(0 - ddx) : DW'(ddx)) <= DW'(tol_r))
             && ((ddy[DW-1] ? DW'(0 - ddy) : DW'(ddy)) <= DW'(tol_r));

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      k_r[0] <= '0;
      k_r[1] <= '0;
      k_r[2] <= '0;
      k_r[3] <= '0;
      k_r[4] <= '0;
      tol_r  <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CENTER_X: cx_r   <= cfg_data[CW-1:0];
        REG_CENTER_Y: cy_r   <= cfg_data[CW-1:0];
        REG_COEFF_0:  k_r[0] <= cfg_data;
        REG_COEFF_1:  k_r[1] <= cfg_data;
        REG_COEFF_2:  k_r[2] <= cfg_data;
        REG_COEFF_3:  k_r[3] <= cfg_data;
        REG_COEFF_4:  k_r[4] <= cfg_data;
        default:      tol_r  <= cfg_data[TOLW-1:0];
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_go_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r    <= 1'b0;
      sqrt_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            kind_r  <= in_data.kind;
            x_r     <= in_data.in_x;
            y_r     <= in_data.in_y;
            tx_r    <= in_data.in_x;
            ty_r    <= in_data.in_y;
            round_r <= '0;
            state_r <= S_OFFS;
          end
        end
        S_OFFS: begin
          dx_r     <= dxw;
          dy_r     <= dyw;
          mul_a_r  <= AW'(dxw);
          mul_b_r  <= AW'(dxw);
          mul_go_r <= 1'b1;
          state_r  <= S_SQX;
        end
        S_SQX: begin
          if (mul_done) begin
            sumsq_r  <= mul_prod[SSW-1:0];
            mul_a_r  <= AW'(dy_r);
            mul_b_r  <= AW'(dy_r);
            mul_go_r <= 1'b1;
            state_r  <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            sumsq_r   <= sumsq_r + mul_prod[SSW-1:0];
            sqrt_go_r <= 1'b1;
            state_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            r_r <= sqrt_root;
            if (kind_r == KIND_DISTORT && sqrt_root <= NEAR_CENTRE) begin
              // Points at or near the centre (radius up to NEAR_CENTRE) pass through unchanged.
              out_r.out_x     <= x_r;
              out_r.out_y     <= y_r;
              out_r.converged <= 1'b1;
              out_valid_r     <= 1'b1;
              state_r         <= S_IDLE;
            end else begin
              acc_r    <= AW'(k_r[4]);
              hstep_r  <= 3'd3;
              mul_a_r  <= AW'(k_r[4]);
              mul_b_r  <= AW'(sqrt_root);
              mul_go_r <= 1'b1;
              state_r  <= S_HORN;
            end
          end
        end
        S_HORN: begin
          if (mul_done) begin
            acc_r    <= hsum;
            mul_a_r  <= hsum;
            mul_go_r <= 1'b1;
            if (hstep_r == 3'd0) begin
              mul_b_r <= AW'(dx_r);
              state_r <= S_DSPX;
            end else begin
              mul_b_r <= AW'(r_r);
              hstep_r <= hstep_r - 3'd1;
            end
          end
        end
        S_DSPX: begin
          if (mul_done) begin
            mx_r     <= m40;
            mul_a_r  <= acc_r;
            mul_b_r  <= AW'(dy_r);
            mul_go_r <= 1'b1;
            state_r  <= S_DSPY;
          end
        end
        S_DSPY: begin
          if (mul_done) begin
            if (kind_r == KIND_DISTORT || conv || round_r == RND_W'(MAX_ROUNDS - 1)) begin
              out_r.out_x     <= ox_n;
              out_r.out_y     <= oy_n;
              out_r.converged <= (kind_r == KIND_DISTORT) || conv;
              out_valid_r     <= 1'b1;
              state_r         <= S_IDLE;
            end else begin
              tx_r    <= ox_n;
              ty_r    <= oy_n;
              round_r <= round_r + RND_W'(1);
              state_r <= S_OFFS;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Shared arithmetic units.
  rldm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod),
    .neg   (mul_neg)
  );

  rldm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sqrt_go_r),
    .rad   (sumsq_r),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // An accepted request always makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result is only shown once the sequencer has returned to idle.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  // The direct distort path always reports success.
  a_distort_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind_r == KIND_DISTORT) |-> out_data.converged)
    else $error("distort result flagged as not converged");
`endif

endmodule
